>>> src/mi3_pkg.sv
// Shared types and constants for the 3x3 fixed-point matrix inverse.
// No dependencies.
`timescale 1ns / 1ps

package mi3_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int XW            = 32;   // element width
  localparam int PW            = 64;   // 2x2 product width
  localparam int CFW           = 65;   // signed cofactor width
  localparam int MW            = 64;   // cofactor magnitude width
  localparam int DW            = 96;   // determinant magnitude width
  localparam int DETW          = 98;   // signed determinant width
  localparam int NSTEP         = 32;   // quotient bits, one per stage
  localparam int NFRONT        = 6;    // cofactor and determinant stages
  localparam int NELEM         = 9;

  // Element indices {a, b, c, d} of cofactor k = A[a]*A[b] - A[c]*A[d].
  localparam int unsigned COF_IDX [NELEM][4] = '{
    '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
    '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
    '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
  };

  typedef struct packed {
    logic [NSTEP-1:0] q;
    logic             ovf;
    logic             neg;
  } lane_res_t;

endpackage

>>> src/mi3_front.sv
// Cofactor and determinant pipeline: products, cofactors, determinant, magnitudes.
// Depends on mi3_pkg.
`timescale 1ns / 1ps

module mi3_front (
  input  logic                                   clk,
  input  logic [mi3_pkg::NFRONT-1:0]             free,
  input  logic signed [mi3_pkg::XW-1:0]          a_in [mi3_pkg::NELEM],
  output logic [mi3_pkg::MW-1:0]                 cabs [mi3_pkg::NELEM],
  output logic                                   cneg [mi3_pkg::NELEM],
  output logic [mi3_pkg::DW-1:0]                 dabs,
  output logic                                   sing
);

  logic signed [mi3_pkg::PW-1:0]   p_s0 [mi3_pkg::NELEM];
  logic signed [mi3_pkg::PW-1:0]   q_s0 [mi3_pkg::NELEM];
  logic signed [mi3_pkg::XW-1:0]   row_s0 [3];
  logic signed [mi3_pkg::XW-1:0]   row_s1 [3];
  logic signed [mi3_pkg::CFW-1:0]  cof_s1 [mi3_pkg::NELEM];
  logic signed [mi3_pkg::CFW-1:0]  cof_s2 [mi3_pkg::NELEM];
  logic signed [mi3_pkg::CFW-1:0]  cof_s3 [mi3_pkg::NELEM];
  logic signed [mi3_pkg::CFW-1:0]  cof_s4 [mi3_pkg::NELEM];
  logic signed [mi3_pkg::CFW-1:0]  pl_s2 [3];
  logic signed [mi3_pkg::CFW-1:0]  ph_s2 [3];
  logic signed [mi3_pkg::DETW-2:0] t_s3 [3];
  logic signed [mi3_pkg::DETW-1:0] det_s4;
  logic signed [mi3_pkg::DETW-1:0] det_neg;

  assign det_neg = -det_s4;

  always_ff @(posedge clk) begin
    if (free[0]) begin
      for (int k = 0; k < mi3_pkg::NELEM; k++) begin
        p_s0[k] <= a_in[mi3_pkg::COF_IDX[k][0]] * a_in[mi3_pkg::COF_IDX[k][1]];
        q_s0[k] <= a_in[mi3_pkg::COF_IDX[k][2]] * a_in[mi3_pkg::COF_IDX[k][3]];
      end
      for (int r = 0; r < 3; r++) row_s0[r] <= a_in[r];
    end
    if (free[1]) begin
      for (int k = 0; k < mi3_pkg::NELEM; k++)
        cof_s1[k] <= mi3_pkg::CFW'(p_s0[k]) - mi3_pkg::CFW'(q_s0[k]);
      row_s1 <= row_s0;
    end
    if (free[2]) begin
      for (int r = 0; r < 3; r++) begin
        pl_s2[r] <= row_s1[r] * $signed({1'b0, cof_s1[3*r][31:0]});
        ph_s2[r] <= row_s1[r] * $signed(cof_s1[3*r][mi3_pkg::CFW-1:32]);
      end
      cof_s2 <= cof_s1;
    end
    if (free[3]) begin
      for (int r = 0; r < 3; r++)
        t_s3[r] <= $signed({ph_s2[r], 32'd0}) + (mi3_pkg::DETW-1)'(pl_s2[r]);
      cof_s3 <= cof_s2;
    end
    if (free[4]) begin
      det_s4 <= mi3_pkg::DETW'(t_s3[0]) + mi3_pkg::DETW'(t_s3[1])
              + mi3_pkg::DETW'(t_s3[2]);
      cof_s4 <= cof_s3;
    end
    if (free[5]) begin
      dabs <= det_s4[mi3_pkg::DETW-1] ? det_neg[mi3_pkg::DW-1:0] : det_s4[mi3_pkg::DW-1:0];
      sing <= (det_s4 == '0);
      for (int k = 0; k < mi3_pkg::NELEM; k++) begin
        cabs[k] <= cof_s4[k][mi3_pkg::CFW-1] ? mi3_pkg::MW'(-cof_s4[k])
                                            : cof_s4[k][mi3_pkg::MW-1:0];
        cneg[k] <= cof_s4[k][mi3_pkg::CFW-1] ^ det_s4[mi3_pkg::DETW-1];
      end
    end
  end

endmodule

>>> src/mi3_div_lane.sv
// One division lane: overflow check, then one restoring quotient bit per stage.
// Depends on mi3_pkg.
`timescale 1ns / 1ps

module mi3_div_lane #(
  parameter int FRAC_BITS = mi3_pkg::FRAC_BITS_DEF
) (
  input  logic                                       clk,
  input  logic [mi3_pkg::NSTEP:0]                    free,
  input  logic [mi3_pkg::MW-1:0]                     cabs,
  input  logic                                       cneg,
  input  logic [mi3_pkg::DW-1:0]                     dpre,
  input  logic [mi3_pkg::NSTEP-1:0][mi3_pkg::DW-1:0] dline,
  output mi3_pkg::lane_res_t                         res
);

  localparam int NW = mi3_pkg::MW + 2 * FRAC_BITS;

  logic [NW-1:0]                num;
  logic [mi3_pkg::DW-1:0]       hi;
  logic [mi3_pkg::DW-1:0]       rem [mi3_pkg::NSTEP+1];
  logic [mi3_pkg::NSTEP-1:0]    nb  [mi3_pkg::NSTEP+1];
  logic [mi3_pkg::NSTEP-1:0]    q   [mi3_pkg::NSTEP+1];
  logic                         ovf [mi3_pkg::NSTEP+1];
  logic                         neg [mi3_pkg::NSTEP+1];

  assign num = NW'(cabs) << (2 * FRAC_BITS);
  assign hi  = mi3_pkg::DW'(num[NW-1:mi3_pkg::NSTEP]);

  always_ff @(posedge clk) begin
    if (free[0]) begin
      rem[0] <= hi;
      nb[0]  <= num[mi3_pkg::NSTEP-1:0];
      q[0]   <= '0;
      ovf[0] <= (hi >= dpre);
      neg[0] <= cneg;
    end
  end

  for (genvar j = 1; j <= mi3_pkg::NSTEP; j++) begin : g_step
    logic [mi3_pkg::DW:0] t;
    logic [mi3_pkg::DW:0] diff;
    logic                 ge;

    assign t    = {rem[j-1], nb[j-1][mi3_pkg::NSTEP-1]};
    assign diff = t - {1'b0, dline[j-1]};
    assign ge   = (t >= {1'b0, dline[j-1]});

    always_ff @(posedge clk) begin
      if (free[j]) begin
        rem[j] <= ge ? diff[mi3_pkg::DW-1:0] : t[mi3_pkg::DW-1:0];
        nb[j]  <= {nb[j-1][mi3_pkg::NSTEP-2:0], 1'b0};
        q[j]   <= {q[j-1][mi3_pkg::NSTEP-2:0], ge};
        ovf[j] <= ovf[j-1];
        neg[j] <= neg[j-1];
      end
    end
  end

  assign res.q   = q[mi3_pkg::NSTEP];
  assign res.ovf = ovf[mi3_pkg::NSTEP];
  assign res.neg = neg[mi3_pkg::NSTEP];

endmodule

>>> src/mi3_merge.sv
// Output stage: saturate and sign the nine quotients, merge flags, hold the result.
// Depends on mi3_pkg.
`timescale 1ns / 1ps

module mi3_merge (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  mi3_pkg::lane_res_t            res [mi3_pkg::NELEM],
  input  logic                          sing,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic                          free_in,
  output logic [mi3_pkg::XW-1:0]        data [mi3_pkg::NELEM],
  output logic                          singular,
  output logic                          saturated
);

  localparam logic [mi3_pkg::XW-1:0] LIM_POS = {1'b0, {(mi3_pkg::XW-1){1'b1}}};
  localparam logic [mi3_pkg::XW-1:0] LIM_NEG = {1'b1, {(mi3_pkg::XW-1){1'b0}}};

  logic [mi3_pkg::XW-1:0] data_next [mi3_pkg::NELEM];
  logic                   sat_next;

  assign free_in = !out_valid || out_ready;

  always_comb begin
    logic [mi3_pkg::XW-1:0] lim;
    logic [mi3_pkg::XW-1:0] mag;
    logic                   sk;
    sat_next = 1'b0;
    for (int k = 0; k < mi3_pkg::NELEM; k++) begin
      lim = res[k].neg ? LIM_NEG : LIM_POS;
      sk  = res[k].ovf || (res[k].q > lim);
      mag = sk ? lim : res[k].q;
      data_next[k] = sing ? '0 : (res[k].neg ? (~mag + 1'b1) : mag);
      sat_next = sat_next | sk;
    end
    if (sing) sat_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (free_in) begin
      out_valid <= in_valid;
    end
    if (free_in) begin
      data      <= data_next;
      singular  <= sing;
      saturated <= sat_next;
    end
  end

endmodule

>>> src/matrix_inverse_3x3_core.sv
// 3x3 Q-format matrix inverse by the adjugate: one matrix per clock while the
// output is not stalled. Six stages form exact cofactors and the determinant,
// nine division lanes (one per element) then resolve one quotient bit per
// stage over 32 stages after an overflow check, and a registered output stage
// saturates and signs the results. Stages advance independently, so bubbles
// close up while the output waits. Depends on mi3_pkg and the mi3_* modules.
`timescale 1ns / 1ps

module matrix_inverse_3x3_core #(
  parameter int FRAC_BITS = mi3_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_r0c0,
  input  logic [31:0] in_r0c1,
  input  logic [31:0] in_r0c2,
  input  logic [31:0] in_r1c0,
  input  logic [31:0] in_r1c1,
  input  logic [31:0] in_r1c2,
  input  logic [31:0] in_r2c0,
  input  logic [31:0] in_r2c1,
  input  logic [31:0] in_r2c2,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_r0c0,
  output logic [31:0] out_r0c1,
  output logic [31:0] out_r0c2,
  output logic [31:0] out_r1c0,
  output logic [31:0] out_r1c1,
  output logic [31:0] out_r1c2,
  output logic [31:0] out_r2c0,
  output logic [31:0] out_r2c1,
  output logic [31:0] out_r2c2,
  output logic        singular,
  output logic        saturated
);

  localparam int NS = mi3_pkg::NFRONT + mi3_pkg::NSTEP + 1;

  logic [NS-1:0]                  v;
  logic [NS:0]                    free;
  logic signed [mi3_pkg::XW-1:0]  a_in [mi3_pkg::NELEM];
  logic [mi3_pkg::MW-1:0]         cabs [mi3_pkg::NELEM];
  logic                           cneg [mi3_pkg::NELEM];
  logic [mi3_pkg::DW-1:0]         dabs;
  logic                           sing;
  logic [mi3_pkg::NSTEP-1:0][mi3_pkg::DW-1:0] dline;
  logic [mi3_pkg::NSTEP:0]        sline;
  mi3_pkg::lane_res_t             res [mi3_pkg::NELEM];
  logic [mi3_pkg::XW-1:0]         data [mi3_pkg::NELEM];
  logic                           free_out;

  assign a_in[0] = $signed(in_r0c0);
  assign a_in[1] = $signed(in_r0c1);
  assign a_in[2] = $signed(in_r0c2);
  assign a_in[3] = $signed(in_r1c0);
  assign a_in[4] = $signed(in_r1c1);
  assign a_in[5] = $signed(in_r1c2);
  assign a_in[6] = $signed(in_r2c0);
  assign a_in[7] = $signed(in_r2c1);
  assign a_in[8] = $signed(in_r2c2);

  always_comb begin
    free[NS] = free_out;
    for (int i = NS - 1; i >= 0; i--) free[i] = !v[i] || free[i+1];
  end

  assign in_ready = free[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (free[0]) v[0] <= in_valid;
      for (int i = 1; i < NS; i++)
        if (free[i]) v[i] <= v[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (free[mi3_pkg::NFRONT]) begin
      dline[0] <= dabs;
      sline[0] <= sing;
    end
    for (int j = 1; j < mi3_pkg::NSTEP; j++)
      if (free[mi3_pkg::NFRONT+j]) dline[j] <= dline[j-1];
    for (int j = 1; j <= mi3_pkg::NSTEP; j++)
      if (free[mi3_pkg::NFRONT+j]) sline[j] <= sline[j-1];
  end

  mi3_front u_front (
    .clk  (clk),
    .free (free[mi3_pkg::NFRONT-1:0]),
    .a_in (a_in),
    .cabs (cabs),
    .cneg (cneg),
    .dabs (dabs),
    .sing (sing)
  );

  for (genvar k = 0; k < mi3_pkg::NELEM; k++) begin : g_lane
    mi3_div_lane #(
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk   (clk),
      .free  (free[NS-1:mi3_pkg::NFRONT]),
      .cabs  (cabs[k]),
      .cneg  (cneg[k]),
      .dpre  (dabs),
      .dline (dline),
      .res   (res[k])
    );
  end

  mi3_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v[NS-1]),
    .res       (res),
    .sing      (sline[mi3_pkg::NSTEP]),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .free_in   (free_out),
    .data      (data),
    .singular  (singular),
    .saturated (saturated)
  );

  assign out_r0c0 = data[0];
  assign out_r0c1 = data[1];
  assign out_r0c2 = data[2];
  assign out_r1c0 = data[3];
  assign out_r1c1 = data[4];
  assign out_r1c2 = data[5];
  assign out_r2c0 = data[6];
  assign out_r2c1 = data[7];
  assign out_r2c2 = data[8];

  a_singular_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && singular |-> !saturated && out_r0c0 == '0 && out_r1c1 == '0
      && out_r2c2 == '0 && out_r0c2 == '0 && out_r2c0 == '0)
    else $error("singular result carries nonzero data");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("request refused with output stage empty");

  a_last_held: assert property (@(posedge clk) disable iff (rst)
    v[NS-1] && !free[NS-1] |=> v[NS-1])
    else $error("stalled item dropped from last lane stage");

endmodule
